/* rtl/core/kead_pkg.sv */
// Shared types, constants, key table and key-code decode for the keypad decoder.
`default_nettype none

package kead_pkg;

  // Item payloads.
  typedef struct packed {
    logic [63:0] scan_high;
    logic [63:0] scan_low;
  } kead_scan_t;

  typedef struct packed {
    logic [6:0] character;
    logic [1:0] cursor_mode;
    logic       cursor_mode_valid;
  } kead_result_t;

  // Cursor styles reported with a mode update.
  typedef enum logic [1:0] {
    CurNormal = 2'd0,
    CurShift  = 2'd1,
    CurCaps   = 2'd2,
    CurCtrl   = 2'd3
  } cursor_e;

  // Configuration register indexes.
  typedef enum logic {
    CfgAlphaKey = 1'b0,
    CfgShiftKey = 1'b1
  } cfg_idx_e;

  localparam int unsigned KeyCodeW   = 7;
  localparam int unsigned ColumnW    = 3;
  localparam int unsigned CharW      = 7;
  // Only matrix words 0 to 4 can be named by a key code.
  localparam int unsigned UsedWords  = 5;
  localparam int unsigned UsedBits   = UsedWords * 16;
  localparam int unsigned PosW       = $clog2(UsedBits);

  localparam int unsigned StoredRows = 50;
  localparam int unsigned DefNumKeys    = 50;
  localparam int unsigned DefNumColumns = 7;

  localparam logic [KeyCodeW-1:0] AlphaKeyReset = 7'd77;
  localparam logic [KeyCodeW-1:0] ShiftKeyReset = 7'd78;

  // Table columns selected by the modifier state.
  localparam logic [ColumnW-1:0] ColNormal = 3'd1;
  localparam logic [ColumnW-1:0] ColCaps   = 3'd2;
  localparam logic [ColumnW-1:0] ColShift  = 3'd3;
  localparam logic [ColumnW-1:0] ColCtrl   = 3'd4;

  // Special characters.
  localparam logic [CharW-1:0] ChNoKey = 7'd1;

  // Division by ten of a key code through a reciprocal multiply.
  localparam logic [14:0] DivTenMul = 15'd205;
  localparam int unsigned DivTenShift = 11;

  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] pos;
  } kead_keypos_t;

  typedef struct packed {
    logic            alpha_hit;
    logic [PosW-1:0] alpha_pos;
    logic            shift_hit;
    logic [PosW-1:0] shift_pos;
  } kead_keys_t;

  typedef struct packed {
    logic [ColumnW-1:0] column;
    cursor_e            cursor_mode;
    logic               cursor_valid;
    logic               modifier_hit;
  } kead_mode_t;

  // Each row: key code, then the characters of columns one to seven.
  localparam logic [7:0] KeyMap [StoredRows][8] = '{
    '{8'd79, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd69, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd59, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd49, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd39, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd29, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd78, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd68, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd58, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd48, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd38, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2},
    '{8'd28, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16},
    '{8'd77, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd67, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd57, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd47, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27},
    '{8'd37, 8'd14, 8'd14, 8'd14, 8'd14, 8'd14, 8'd14, 8'd14},
    '{8'd27, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6},
    '{8'd76, 8'd1, 8'd65, 8'd1, 8'd97, 8'd1, 8'd1, 8'd1},
    '{8'd66, 8'd1, 8'd66, 8'd1, 8'd98, 8'd2, 8'd1, 8'd1},
    '{8'd56, 8'd1, 8'd67, 8'd1, 8'd99, 8'd3, 8'd1, 8'd1},
    '{8'd46, 8'd1, 8'd68, 8'd1, 8'd100, 8'd4, 8'd1, 8'd1},
    '{8'd36, 8'd1, 8'd69, 8'd1, 8'd101, 8'd5, 8'd1, 8'd1},
    '{8'd26, 8'd1, 8'd70, 8'd1, 8'd102, 8'd6, 8'd1, 8'd1},
    '{8'd75, 8'd1, 8'd71, 8'd1, 8'd103, 8'd7, 8'd1, 8'd1},
    '{8'd65, 8'd9, 8'd72, 8'd1, 8'd104, 8'd8, 8'd1, 8'd1},
    '{8'd55, 8'd40, 8'd73, 8'd1, 8'd105, 8'd9, 8'd1, 8'd1},
    '{8'd45, 8'd41, 8'd74, 8'd1, 8'd106, 8'd10, 8'd1, 8'd1},
    '{8'd35, 8'd44, 8'd75, 8'd1, 8'd107, 8'd11, 8'd1, 8'd1},
    '{8'd25, 8'd1, 8'd76, 8'd1, 8'd108, 8'd12, 8'd1, 8'd1},
    '{8'd74, 8'd55, 8'd77, 8'd38, 8'd109, 8'd13, 8'd1, 8'd1},
    '{8'd64, 8'd56, 8'd78, 8'd1, 8'd110, 8'd14, 8'd1, 8'd1},
    '{8'd54, 8'd57, 8'd79, 8'd1, 8'd111, 8'd15, 8'd1, 8'd1},
    '{8'd44, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8},
    '{8'd10, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3},
    '{8'd73, 8'd52, 8'd80, 8'd36, 8'd112, 8'd16, 8'd1, 8'd1},
    '{8'd63, 8'd53, 8'd81, 8'd37, 8'd113, 8'd17, 8'd1, 8'd1},
    '{8'd53, 8'd54, 8'd82, 8'd94, 8'd114, 8'd18, 8'd1, 8'd1},
    '{8'd43, 8'd42, 8'd83, 8'd123, 8'd115, 8'd19, 8'd1, 8'd1},
    '{8'd33, 8'd47, 8'd84, 8'd125, 8'd116, 8'd20, 8'd1, 8'd1},
    '{8'd72, 8'd49, 8'd85, 8'd33, 8'd117, 8'd21, 8'd1, 8'd1},
    '{8'd62, 8'd50, 8'd86, 8'd64, 8'd118, 8'd22, 8'd1, 8'd1},
    '{8'd52, 8'd51, 8'd87, 8'd35, 8'd119, 8'd23, 8'd1, 8'd1},
    '{8'd42, 8'd43, 8'd88, 8'd91, 8'd120, 8'd24, 8'd1, 8'd1},
    '{8'd32, 8'd45, 8'd89, 8'd93, 8'd121, 8'd25, 8'd1, 8'd1},
    '{8'd71, 8'd48, 8'd90, 8'd1, 8'd122, 8'd26, 8'd1, 8'd1},
    '{8'd61, 8'd46, 8'd32, 8'd61, 8'd32, 8'd1, 8'd1, 8'd1},
    '{8'd51, 8'd63, 8'd34, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
    '{8'd41, 8'd95, 8'd59, 8'd58, 8'd45, 8'd1, 8'd1, 8'd1},
    '{8'd31, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10}
  };

  // Maps a key code to its bit in the used matrix words. The row digit picks
  // the word (row / 2) and the byte (row odd: upper byte); the tens digit
  // minus one picks the bit. A code below ten or a bit past fifteen misses.
  function automatic kead_keypos_t key_pos(input logic [KeyCodeW-1:0] code);
    logic [14:0]   prod;
    logic [3:0]    tens;
    logic [3:0]    row;
    logic [4:0]    bit_idx;
    kead_keypos_t  res;
    prod    = 15'(code) * DivTenMul;
    tens    = prod[DivTenShift +: 4];
    row     = 4'(code - 7'(7'(tens) * 7'd10));
    bit_idx = 5'(tens) - 5'd1 + (row[0] ? 5'd8 : 5'd0);
    res.hit = (tens != 4'd0) && (bit_idx <= 5'd15);
    res.pos = {row[3:1], bit_idx[3:0]};
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kead_cfg_regs.sv */
// Modifier key-code registers and their decode to matrix bit positions.
`default_nettype none

module kead_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire kead_pkg::cfg_idx_e            cfg_idx_i,
  input  wire logic [kead_pkg::KeyCodeW-1:0] cfg_wdata_i,
  output kead_pkg::kead_keys_t               keys_o
);
  import kead_pkg::*;

  logic [KeyCodeW-1:0] alpha_code_q, alpha_code_d;
  logic [KeyCodeW-1:0] shift_code_q, shift_code_d;
  kead_keypos_t        alpha_pos;
  kead_keypos_t        shift_pos;

  // Register writes.
  always_comb begin
    alpha_code_d = alpha_code_q;
    shift_code_d = shift_code_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAlphaKey: alpha_code_d = cfg_wdata_i;
        CfgShiftKey: shift_code_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_code_q <= AlphaKeyReset;
      shift_code_q <= ShiftKeyReset;
    end else begin
      alpha_code_q <= alpha_code_d;
      shift_code_q <= shift_code_d;
    end
  end

  // Decode the codes to bit positions in the scan.
  assign alpha_pos = key_pos(alpha_code_q);
  assign shift_pos = key_pos(shift_code_q);

  assign keys_o.alpha_hit = alpha_pos.hit;
  assign keys_o.alpha_pos = alpha_pos.pos;
  assign keys_o.shift_hit = shift_pos.hit;
  assign keys_o.shift_pos = shift_pos.pos;

endmodule

`default_nettype wire

/* rtl/core/kead_modifier.sv */
// Shift, caps and ctrl modifier state and the cursor-mode update it reports.
`default_nettype none

module kead_modifier (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic             alpha_edge_i,
  input  wire logic             shift_edge_i,
  output kead_pkg::kead_mode_t  mode_o
);
  import kead_pkg::*;

  logic               shift_q, shift_d;
  logic               caps_q, caps_d;
  logic               ctrl_q, ctrl_d;
  logic [ColumnW-1:0] column_q, column_d;

  // Next modifier state and the mode update for the scan in flight.
  always_comb begin
    shift_d             = shift_q;
    caps_d              = caps_q;
    ctrl_d              = ctrl_q;
    column_d            = column_q;
    mode_o.cursor_mode  = CurNormal;
    mode_o.cursor_valid = 1'b0;
    mode_o.modifier_hit = 1'b0;
    // Caps forces the upper-case column for ordinary keys.
    mode_o.column       = caps_q ? ColCaps : column_q;

    if (alpha_edge_i) begin
      mode_o.modifier_hit = 1'b1;
      mode_o.cursor_valid = 1'b1;
      ctrl_d              = !ctrl_q;
      if (ctrl_q) begin
        column_d           = ColNormal;
        mode_o.cursor_mode = CurNormal;
      end else begin
        column_d           = ColCtrl;
        mode_o.cursor_mode = CurCtrl;
      end
    end else if (shift_edge_i) begin
      mode_o.modifier_hit = 1'b1;
      mode_o.cursor_valid = 1'b1;
      if (ctrl_q) begin
        ctrl_d             = 1'b0;
        shift_d            = 1'b0;
        caps_d             = 1'b1;
        column_d           = ColCaps;
        mode_o.cursor_mode = CurCaps;
      end else if (caps_q) begin
        caps_d             = 1'b0;
        column_d           = ColNormal;
        mode_o.cursor_mode = CurNormal;
      end else if (shift_q) begin
        shift_d            = 1'b0;
        column_d           = ColNormal;
        mode_o.cursor_mode = CurNormal;
      end else begin
        shift_d            = 1'b1;
        column_d           = ColShift;
        mode_o.cursor_mode = CurShift;
      end
    end else if (caps_q) begin
      column_d            = ColCaps;
      mode_o.cursor_mode  = CurCaps;
      mode_o.cursor_valid = 1'b1;
    end
  end

  // State moves only when a scan transfers to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      ctrl_q   <= 1'b0;
      column_q <= ColNormal;
    end else if (advance_i) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      ctrl_q   <= ctrl_d;
      column_q <= column_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kead_key_lookup.sv */
// Priority select of the first table key with a new press and its character.
`default_nettype none

module kead_key_lookup #(
  parameter int unsigned NUM_KEYS    = kead_pkg::DefNumKeys,
  parameter int unsigned NUM_COLUMNS = kead_pkg::DefNumColumns
) (
  input  wire logic [kead_pkg::UsedBits-1:0] edge_i,
  input  wire logic [kead_pkg::ColumnW-1:0]  column_i,
  output logic [kead_pkg::CharW-1:0]         character_o
);
  import kead_pkg::*;

  localparam int unsigned ActiveRows = (NUM_KEYS < StoredRows) ? NUM_KEYS : StoredRows;

  logic         column_ok;
  kead_keypos_t row_pos;
  logic [7:0]   entry;

  assign column_ok = (column_i >= 3'd1) && (int'(column_i) <= NUM_COLUMNS);

  // Walk from the last row down so that the first matching row wins.
  always_comb begin
    character_o = ChNoKey;
    row_pos     = '0;
    entry       = '0;
    for (int i = ActiveRows - 1; i >= 0; i--) begin
      row_pos = key_pos(KeyMap[i][0][KeyCodeW-1:0]);
      if (row_pos.hit && edge_i[row_pos.pos]) begin
        entry       = KeyMap[i][column_i];
        character_o = column_ok ? entry[CharW-1:0] : ChNoKey;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/keypad_edge_ascii_decoder.sv */
// Top level of the keypad edge decoder: scan register, decode and result register.
`default_nettype none

// Takes one key-matrix scan per transfer and returns one result per scan: the
// character of the first table key newly pressed since the previous scan
// (1 when none, 0 for abort), plus a cursor-mode update when the alpha or
// shift key was pressed or caps is on. A new scan is accepted every cycle
// while the result side does not hold it back; each scan is held in the input
// register and then lands in the result register, from which its result is
// offered. The priority select over the key table between those two
// registers sets the cycle time. Back-pressure on the result side stalls the
// input register, and the previous scan and modifier state move only when a
// scan reaches the result register. The user must write the alpha and shift
// key codes through the configuration port only while no scan is in flight;
// the block itself does not enforce this.
module keypad_edge_ascii_decoder #(
  parameter int unsigned NUM_KEYS    = kead_pkg::DefNumKeys,
  parameter int unsigned NUM_COLUMNS = kead_pkg::DefNumColumns
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire kead_pkg::kead_scan_t          scan_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output kead_pkg::kead_result_t             result_o,
  input  wire logic                          cfg_we_i,
  input  wire kead_pkg::cfg_idx_e            cfg_idx_i,
  input  wire logic [kead_pkg::KeyCodeW-1:0] cfg_wdata_i
);
  import kead_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  logic [UsedBits-1:0] s1_scan_q;
  logic [UsedBits-1:0] prev_scan_q;
  logic                out_valid_q, out_valid_d;
  kead_result_t        out_q, out_d;
  logic                in_xfer;
  logic                advance;
  logic [UsedBits-1:0] key_edge;
  logic                alpha_edge;
  logic                shift_edge;
  kead_keys_t          keys;
  kead_mode_t          mode;
  logic [CharW-1:0]    table_char;

  // Handshake: the input register moves on whenever the result slot frees.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_xfer || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input register keeps only the words a key code can reach.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_scan_q <= {scan_i.scan_high[UsedBits-65:0], scan_i.scan_low};
    end
  end

  // Previous scan advances with each decoded scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_scan_q <= '0;
    end else if (advance) begin
      prev_scan_q <= s1_scan_q;
    end
  end

  assign key_edge   = s1_scan_q & ~prev_scan_q;
  assign alpha_edge = keys.alpha_hit && key_edge[keys.alpha_pos];
  assign shift_edge = keys.shift_hit && key_edge[keys.shift_pos];

  kead_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  kead_modifier u_modifier (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .alpha_edge_i (alpha_edge),
    .shift_edge_i (shift_edge),
    .mode_o       (mode)
  );

  kead_key_lookup #(
    .NUM_KEYS    (NUM_KEYS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_key_lookup (
    .edge_i      (key_edge),
    .column_i    (mode.column),
    .character_o (table_char)
  );

  // Result assembly: a modifier press yields no character.
  always_comb begin
    out_d.character         = mode.modifier_hit ? ChNoKey : table_char;
    out_d.cursor_mode       = mode.cursor_mode;
    out_d.cursor_mode_valid = mode.cursor_valid;
  end

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

/* rtl/core/kead_checker.sv */
// Port-level checks for the keypad edge decoder, bound to its top level.
`default_nettype none

module kead_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire kead_pkg::kead_result_t result_o
);
  import kead_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed or dropped while stalled");

  // With no result waiting, the block must take a scan.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

  // Without a mode update the cursor field reads as normal.
  a_mode_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_o.cursor_mode_valid |-> result_o.cursor_mode == CurNormal)
    else $error("cursor mode set without update");

  // Of the results with a mode update, only a caps report can come with a real character.
  a_mod_nochar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_o.cursor_mode_valid && result_o.cursor_mode != CurCaps
    |-> result_o.character == ChNoKey)
    else $error("character delivered with a modifier press");

endmodule

bind keypad_edge_ascii_decoder kead_checker u_kead_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the keypad edge decoder: directed scans, then random scans.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kead_pkg::*;

  localparam int NUM_ROWS    = 50;
  localparam int NUM_COLS    = 7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 185;
  localparam int NUM_PHASES  = 7;

  // Character table columns picked by the modifier state.
  localparam int COL_PLAIN  = 1;
  localparam int COL_UPPER  = 2;
  localparam int COL_SYMBOL = 3;
  localparam int COL_CTRL   = 4;

  localparam logic [6:0] NO_KEY = 7'd1;
  localparam logic [6:0] ABORT  = 7'd0;

  // Idle styles of either side.
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_LIGHT = 2;

  // Key code, then the characters of columns one to seven.
  localparam logic [7:0] KEY_TAB [NUM_ROWS][8] = '{
    '{79, 1, 1, 1, 1, 1, 1, 1}, '{69, 1, 1, 1, 1, 1, 1, 1},
    '{59, 1, 1, 1, 1, 1, 1, 1}, '{49, 1, 1, 1, 1, 1, 1, 1},
    '{39, 1, 1, 1, 1, 1, 1, 1}, '{29, 1, 1, 1, 1, 1, 1, 1},
    '{78, 1, 1, 1, 1, 1, 1, 1}, '{68, 1, 1, 1, 1, 1, 1, 1},
    '{58, 1, 1, 1, 1, 1, 1, 1}, '{48, 0, 0, 0, 0, 0, 0, 0},
    '{38, 2, 2, 2, 2, 2, 2, 2}, '{28, 16, 16, 16, 16, 16, 16, 16},
    '{77, 1, 1, 1, 1, 1, 1, 1}, '{67, 1, 1, 1, 1, 1, 1, 1},
    '{57, 1, 1, 1, 1, 1, 1, 1}, '{47, 27, 27, 27, 27, 27, 27, 27},
    '{37, 14, 14, 14, 14, 14, 14, 14}, '{27, 6, 6, 6, 6, 6, 6, 6},
    '{76, 1, 65, 1, 97, 1, 1, 1}, '{66, 1, 66, 1, 98, 2, 1, 1},
    '{56, 1, 67, 1, 99, 3, 1, 1}, '{46, 1, 68, 1, 100, 4, 1, 1},
    '{36, 1, 69, 1, 101, 5, 1, 1}, '{26, 1, 70, 1, 102, 6, 1, 1},
    '{75, 1, 71, 1, 103, 7, 1, 1}, '{65, 9, 72, 1, 104, 8, 1, 1},
    '{55, 40, 73, 1, 105, 9, 1, 1}, '{45, 41, 74, 1, 106, 10, 1, 1},
    '{35, 44, 75, 1, 107, 11, 1, 1}, '{25, 1, 76, 1, 108, 12, 1, 1},
    '{74, 55, 77, 38, 109, 13, 1, 1}, '{64, 56, 78, 1, 110, 14, 1, 1},
    '{54, 57, 79, 1, 111, 15, 1, 1}, '{44, 8, 8, 8, 8, 8, 8, 8},
    '{10, 3, 3, 3, 3, 3, 3, 3},
    '{73, 52, 80, 36, 112, 16, 1, 1}, '{63, 53, 81, 37, 113, 17, 1, 1},
    '{53, 54, 82, 94, 114, 18, 1, 1}, '{43, 42, 83, 123, 115, 19, 1, 1},
    '{33, 47, 84, 125, 116, 20, 1, 1},
    '{72, 49, 85, 33, 117, 21, 1, 1}, '{62, 50, 86, 64, 118, 22, 1, 1},
    '{52, 51, 87, 35, 119, 23, 1, 1}, '{42, 43, 88, 91, 120, 24, 1, 1},
    '{32, 45, 89, 93, 121, 25, 1, 1},
    '{71, 48, 90, 1, 122, 26, 1, 1}, '{61, 46, 32, 61, 32, 1, 1, 1},
    '{51, 63, 34, 1, 1, 1, 1, 1}, '{41, 95, 59, 58, 45, 1, 1, 1},
    '{31, 10, 10, 10, 10, 10, 10, 10}
  };

  typedef struct {
    logic [127:0]  scan;
    bit            typed;
    kead_result_t  want;
  } scan_step_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  kead_scan_t    scan_i;
  logic          out_valid_o;
  logic          out_ready_i;
  kead_result_t  result_o;
  logic          cfg_we_i;
  cfg_idx_e      cfg_idx_i;
  logic [6:0]    cfg_wdata_i;

  // Decoder state mirrored by the testbench.
  logic [127:0]  held_scan;
  logic [127:0]  prior_scan;
  int            map_col;
  bit            shift_on;
  bit            caps_on;
  bit            ctrl_on;
  logic [6:0]    alpha_code;
  logic [6:0]    shift_code;

  kead_result_t  pending_chars[$];
  scan_step_t    directed_steps[$];
  int            mismatches;
  int            src_style;
  int            sink_style;

  keypad_edge_ascii_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .scan_i      (scan_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Flat matrix bit of a key code: word (row / 2) times sixteen, plus the tens
  // digit minus one, plus eight for an odd row. Returns -1 for a dead code.
  function automatic int key_index(input int code);
    int row;
    int tens;
    int bit_pos;
    row = code % 10;
    tens = code / 10;
    if (tens == 0) return -1;
    bit_pos = tens - 1 + ((row % 2 == 1) ? 8 : 0);
    if (bit_pos > 15) return -1;
    return (row / 2) * 16 + bit_pos;
  endfunction

  function automatic logic [127:0] key_down(input int code);
    logic [127:0] v;
    int idx;
    v = '0;
    idx = key_index(code);
    if (idx >= 0) v[idx] = 1'b1;
    return v;
  endfunction

  function automatic bit newly_down(input logic [6:0] code);
    int idx;
    idx = key_index(int'(code));
    return idx >= 0 && held_scan[idx] && !prior_scan[idx];
  endfunction

  // Works out the result of one accepted scan and advances the mirrored state.
  task automatic decode_scan(input logic [127:0] s, output kead_result_t r);
    r.character = NO_KEY;
    r.cursor_mode = CurNormal;
    r.cursor_mode_valid = 1'b0;
    prior_scan = held_scan;
    held_scan = s;
    if (newly_down(alpha_code)) begin
      ctrl_on = !ctrl_on;
      map_col = ctrl_on ? COL_CTRL : COL_PLAIN;
      r.cursor_mode = ctrl_on ? CurCtrl : CurNormal;
      r.cursor_mode_valid = 1'b1;
    end else if (newly_down(shift_code)) begin
      if (ctrl_on) begin
        ctrl_on = 1'b0;
        shift_on = 1'b0;
        caps_on = 1'b1;
        map_col = COL_UPPER;
        r.cursor_mode = CurCaps;
      end else if (caps_on) begin
        caps_on = 1'b0;
        map_col = COL_PLAIN;
      end else if (shift_on) begin
        shift_on = 1'b0;
        map_col = COL_PLAIN;
      end else begin
        shift_on = 1'b1;
        map_col = COL_SYMBOL;
        r.cursor_mode = CurShift;
      end
      r.cursor_mode_valid = 1'b1;
    end else begin
      // Caps stays reported on every plain scan while it is on.
      if (caps_on) begin
        map_col = COL_UPPER;
        r.cursor_mode = CurCaps;
        r.cursor_mode_valid = 1'b1;
      end
      // The first table key with a press edge wins.
      for (int i = 0; i < NUM_ROWS; i++) begin
        if (newly_down(KEY_TAB[i][0][6:0])) begin
          if (map_col >= 1 && map_col <= NUM_COLS) r.character = KEY_TAB[i][map_col][6:0];
          break;
        end
      end
    end
  endtask

  function automatic int draw_gap(input int style);
    case (style)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return $urandom_range(0, 3);
      default:    return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [127:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic int table_code();
    return int'(KEY_TAB[$urandom_range(0, NUM_ROWS - 1)][0]);
  endfunction

  // Mostly key presses and releases as a user makes them, some noise.
  function automatic logic [127:0] next_scan();
    int pick;
    logic [127:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 30) s = key_down(table_code());
    else if (pick < 45) s = held_scan | key_down(table_code());
    else if (pick < 60)
      s = key_down($urandom_range(0, 1) ? int'(alpha_code) : int'(shift_code)) |
          ($urandom_range(0, 1) ? held_scan : 128'd0);
    else if (pick < 72) s = '0;
    else if (pick < 80) s = held_scan & rand_wide();
    else if (pick < 90) s = rand_wide();
    else s = key_down($urandom_range(0, 127)) | (128'd1 << $urandom_range(0, 127));
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic put_scan(input logic [127:0] s, input bit typed, input kead_result_t want);
    int gap;
    kead_result_t r;
    gap = draw_gap(src_style);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    scan_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    decode_scan(s, r);
    pending_chars.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  // Rewrites both modifier key codes once every result is out.
  task automatic set_keys(input logic [6:0] alpha, input logic [6:0] shift);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgAlphaKey;
    cfg_wdata_i <= alpha;
    @(negedge clk_i);
    cfg_idx_i <= CfgShiftKey;
    cfg_wdata_i <= shift;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    alpha_code = alpha;
    shift_code = shift;
  endtask

  task automatic add_step(input logic [127:0] s, input bit typed, input logic [6:0] ch,
                          input cursor_e mode, input logic vld);
    scan_step_t st;
    st.scan = s;
    st.typed = typed;
    st.want.character = ch;
    st.want.cursor_mode = mode;
    st.want.cursor_mode_valid = vld;
    directed_steps.push_back(st);
  endtask

  // Result side: compare every transfer with the oldest expectation.
  always @(posedge clk_i) begin
    kead_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: char %0d mode %0d valid %0d",
                   result_o.character, result_o.cursor_mode, result_o.cursor_mode_valid);
      end else begin
        exp_r = pending_chars.pop_front();
        if (result_o.character !== exp_r.character ||
            result_o.cursor_mode !== exp_r.cursor_mode ||
            result_o.cursor_mode_valid !== exp_r.cursor_mode_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected char %0d mode %0d valid %0d, ",
                      "got char %0d mode %0d valid %0d"},
                     exp_r.character, exp_r.cursor_mode, exp_r.cursor_mode_valid,
                     result_o.character, result_o.cursor_mode, result_o.cursor_mode_valid);
        end
      end
    end
  end

  // Result side back-pressure, drawn per result.
  initial begin : result_sink
    int gap;
    int served;
    served = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (served % 40 == 0) sink_style = $urandom_range(IDLE_NONE, IDLE_LIGHT);
      gap = draw_gap(sink_style);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      served++;
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("keypad_edge_ascii_decoder verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [6:0] alpha_set [NUM_PHASES] = '{7'd10, 7'd0, 7'd127, 7'd5, 7'd0, 7'd0, 7'd77};
    logic [6:0] shift_set [NUM_PHASES] = '{7'd79, 7'd127, 7'd0, 7'd31, 7'd0, 7'd0, 7'd78};
    logic [127:0] all_ones;
    kead_result_t none;
    int sent;

    all_ones = '1;
    none = '0;
    sent = 0;
    mismatches = 0;
    held_scan = '0;
    prior_scan = '0;
    map_col = COL_PLAIN;
    shift_on = 1'b0;
    caps_on = 1'b0;
    ctrl_on = 1'b0;
    alpha_code = 7'd77;
    shift_code = 7'd78;
    src_style = IDLE_FULL;
    sink_style = IDLE_FULL;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    scan_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgAlphaKey;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed scans with the reset key codes.
    add_step('0, 1, NO_KEY, CurNormal, 1'b0);
    add_step(key_down(48), 1, ABORT, CurNormal, 1'b0);
    add_step(all_ones, 1, NO_KEY, CurCtrl, 1'b1);          // alpha edge in a full matrix
    add_step('0, 1, NO_KEY, CurNormal, 1'b0);
    add_step(key_down(76), 0, NO_KEY, CurNormal, 1'b0);    // letter in ctrl mode
    add_step(key_down(77), 1, NO_KEY, CurNormal, 1'b1);    // ctrl off
    add_step(key_down(78), 1, NO_KEY, CurShift, 1'b1);     // shift on
    add_step(key_down(74), 0, NO_KEY, CurNormal, 1'b0);
    add_step(key_down(78), 1, NO_KEY, CurNormal, 1'b1);    // shift off
    add_step(key_down(77), 1, NO_KEY, CurCtrl, 1'b1);
    add_step(key_down(78), 1, NO_KEY, CurCaps, 1'b1);      // shift in ctrl mode sets caps
    add_step(key_down(76), 0, NO_KEY, CurNormal, 1'b0);    // caps held
    add_step(key_down(78), 1, NO_KEY, CurNormal, 1'b1);    // caps off
    add_step(key_down(77) | key_down(78), 1, NO_KEY, CurCtrl, 1'b1);  // alpha wins
    add_step('0, 0, NO_KEY, CurNormal, 1'b0);
    add_step(key_down(77) | key_down(78), 1, NO_KEY, CurNormal, 1'b1);
    add_step({64'd0, {64{1'b1}}}, 0, NO_KEY, CurNormal, 1'b0);
    add_step({{64{1'b1}}, 64'd0}, 0, NO_KEY, CurNormal, 1'b0);
    add_step(key_down(10), 1, 7'd3, CurNormal, 1'b0);      // lowest live code
    add_step(key_down(31) | key_down(79), 0, NO_KEY, CurNormal, 1'b0);  // table priority
    add_step(key_down(41), 0, NO_KEY, CurNormal, 1'b0);
    add_step('0, 0, NO_KEY, CurNormal, 1'b0);
    foreach (directed_steps[i])
      put_scan(directed_steps[i].scan, directed_steps[i].typed, directed_steps[i].want);

    // Random phases, each under its own pair of modifier key codes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4 || p == 5) begin
        alpha_set[p] = 7'($urandom_range(0, 127));
        shift_set[p] = 7'($urandom_range(0, 127));
      end
      set_keys(alpha_set[p], shift_set[p]);
      @(negedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sent % 40 == 0) src_style = $urandom_range(IDLE_NONE, IDLE_LIGHT);
        put_scan(next_scan(), 1'b0, none);
        sent++;
      end
    end

    // Drain and settle.
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("keypad_edge_ascii_decoder verification clean");
    end else begin
      $display("keypad_edge_ascii_decoder verification failed");
    end
    $finish;
  end

endmodule
